FILE: src/assert_macros.svh
// Assertion helper macros for the sound sequence parser.
// Each check is clocked on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define SSEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent must never be true outside reset
`define SSEQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: src/sseq_pkg.sv
// Shared types, codes and helpers for the sound sequence event parser.
// Used by sseq_state_mem, sseq_parse and sound_sequence_event_parser.
package sseq_pkg;

    localparam int CHANNELS_DEF = 8;

    // Item mode codes (code 3 carries no meaning and is ignored)
    localparam logic [1:0] MODE_STREAM = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    // Byte classes and opcodes
    localparam logic [7:0] BYTE_OPERAND = 8'h80;
    localparam logic [7:0] BYTE_OP_A    = 8'hC0;
    localparam logic [7:0] BYTE_LOW6    = 8'h3F;
    localparam logic [7:0] OPC_END      = 8'h60;
    localparam logic [7:0] OPC_ARG0     = 8'h61;
    localparam logic [7:0] OPC_ARG1     = 8'h62;
    localparam logic [7:0] OPC_ARG2_LO  = 8'h64;
    localparam logic [7:0] OPC_ARG2_HI  = 8'h6A;
    localparam logic [7:0] OPC_ARG3     = 8'h6C;
    localparam logic [7:0] OPC_ARG4_LO  = 8'h6E;
    localparam logic [7:0] OPC_ARG4_HI  = 8'h71;

    // Per-channel parser phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_OPA  = 4'b0010,
        PH_OPB  = 4'b0100,
        PH_ARG  = 4'b1000
    } t_phase;

    // One channel's entry in the state memory
    typedef struct packed {
        t_phase      phase;
        logic [15:0] accum;
        logic [15:0] op_a;
        logic [15:0] op_b;
        logic [6:0]  held;
    } t_chan_state;

    // Input beat
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] chan;
        logic [7:0] stream_byte;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [2:0]         event_chan;
        logic [6:0]         event_opcode;
        logic               is_control;
        logic signed [15:0] op_a;
        logic signed [15:0] op_b;
        logic               has_arg;
        logic [7:0]         ctrl_arg;
        logic [15:0]        duration;
        logic               ended;
    } t_out_item;

    // Control from the parse unit to the pipeline
    typedef struct packed {
        logic emit;
        logic set_active;
        logic clr_active;
    } t_parse_ctl;

    // Controls that hold one argument byte before their event
    function automatic logic needs_arg(input logic [7:0] b);
        return (b == OPC_ARG0) || (b == OPC_ARG1) ||
               ((b >= OPC_ARG2_LO) && (b <= OPC_ARG2_HI)) ||
               (b == OPC_ARG3) ||
               ((b >= OPC_ARG4_LO) && (b <= OPC_ARG4_HI));
    endfunction

endpackage

FILE: src/sseq_state_mem.sv
// Per-channel parser state memory: one write port, one registered read port.
// Depends on sseq_pkg for the entry type.
module sseq_state_mem #(
    parameter int DEPTH  = sseq_pkg::CHANNELS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  sseq_pkg::t_chan_state  i_wdata,
    input  logic                   i_re,
    input  logic [ADDR_W-1:0]      i_raddr,
    output sseq_pkg::t_chan_state  o_rdata
);

    sseq_pkg::t_chan_state r_mem [DEPTH];
    sseq_pkg::t_chan_state r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered (old data on a same-edge write)
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sseq_parse.sv
// Byte parser for one channel: next entry, activity change and event fields.
// Depends on sseq_pkg for types, codes and the argument-opcode list.
module sseq_parse (
    input  logic [1:0]            i_mode,
    input  logic [2:0]            i_chan,
    input  logic [7:0]            i_byte,
    input  logic                  i_active,
    input  sseq_pkg::t_chan_state i_entry,
    output sseq_pkg::t_chan_state o_next,
    output sseq_pkg::t_parse_ctl  o_ctl,
    output sseq_pkg::t_out_item   o_res
);

    sseq_pkg::t_chan_state n_st;
    sseq_pkg::t_parse_ctl  n_ctl;
    logic                  do_fresh;
    logic [6:0]            e_op;
    logic                  e_has;
    logic [7:0]            e_arg;
    logic                  e_end;
    logic                  cont;

    assign cont = (i_byte & sseq_pkg::BYTE_OP_A) == sseq_pkg::BYTE_OP_A;

    always_comb begin
        n_st     = i_entry;
        n_ctl    = '0;
        do_fresh = 1'b0;
        e_op     = '0;
        e_has    = 1'b0;
        e_arg    = '0;
        e_end    = 1'b0;

        case (i_mode)
            sseq_pkg::MODE_START: begin
                n_st = '{phase: sseq_pkg::PH_IDLE, default: '0};
                n_ctl.set_active = 1'b1;
            end
            sseq_pkg::MODE_STOP: begin
                n_st.phase = sseq_pkg::PH_IDLE;
                n_ctl.clr_active = 1'b1;
            end
            sseq_pkg::MODE_STREAM: begin
                if (i_active) begin
                    // Finish whatever the previous bytes left open
                    case (i_entry.phase)
                        sseq_pkg::PH_ARG: begin
                            n_st.phase = sseq_pkg::PH_IDLE;
                            n_ctl.emit = 1'b1;
                            e_op       = i_entry.held;
                            e_has      = 1'b1;
                            e_arg      = i_byte;
                        end
                        sseq_pkg::PH_OPA, sseq_pkg::PH_OPB: begin
                            if (cont) begin
                                n_st.accum = {i_entry.accum[9:0], i_byte[5:0]};
                            end else begin
                                // stored as the negated value
                                if (i_entry.phase == sseq_pkg::PH_OPA) begin
                                    n_st.op_a = ~i_entry.accum + 16'd1;
                                end else begin
                                    n_st.op_b = ~i_entry.accum + 16'd1;
                                end
                                n_st.phase = sseq_pkg::PH_IDLE;
                                do_fresh   = 1'b1;
                            end
                        end
                        default: begin
                            do_fresh = 1'b1;
                        end
                    endcase

                    // Byte taken as the start of a new element
                    if (do_fresh) begin
                        if (i_byte >= sseq_pkg::BYTE_OPERAND) begin
                            n_st.accum = {8'd0, i_byte & sseq_pkg::BYTE_LOW6};
                            n_st.phase = (i_byte >= sseq_pkg::BYTE_OP_A) ?
                                         sseq_pkg::PH_OPA : sseq_pkg::PH_OPB;
                        end else if (i_byte == sseq_pkg::OPC_END) begin
                            n_st.phase       = sseq_pkg::PH_IDLE;
                            n_ctl.emit       = 1'b1;
                            n_ctl.clr_active = 1'b1;
                            e_op             = i_byte[6:0];
                            e_end            = 1'b1;
                        end else if (sseq_pkg::needs_arg(i_byte)) begin
                            n_st.held  = i_byte[6:0];
                            n_st.phase = sseq_pkg::PH_ARG;
                        end else begin
                            n_st.phase = sseq_pkg::PH_IDLE;
                            n_ctl.emit = 1'b1;
                            e_op       = i_byte[6:0];
                        end
                    end
                end
            end
            default: begin
                n_st = i_entry;
            end
        endcase
    end

    // Event fields, taken from the updated operands
    always_comb begin
        o_res.event_chan   = i_chan;
        o_res.event_opcode = e_op;
        o_res.is_control   = ({1'b0, e_op} >= sseq_pkg::OPC_END);
        o_res.op_a         = n_st.op_a;
        o_res.op_b         = n_st.op_b;
        o_res.has_arg      = e_has;
        o_res.ctrl_arg     = e_arg;
        o_res.duration     = n_st.op_a[15] ? (~n_st.op_a + 16'd1) : n_st.op_a;
        o_res.ended        = e_end;
    end

    assign o_next = n_st;
    assign o_ctl  = n_ctl;

endmodule

FILE: src/sound_sequence_event_parser.sv
// Top level of the sound sequence event parser: read stage, parse stage, output register.
// Depends on sseq_pkg, sseq_state_mem, sseq_parse and assert_macros.svh.
//
//   beat      dir   fields          handshake
//   in item   in    t_in_item       i_in_valid / o_in_stall
//   event     out   t_out_item      o_out_valid / i_out_stall
//
// One item a cycle when the input does not stall: the state memory is read at the accept
// edge, the entry is updated in the parse stage and written back when that stage fires,
// with forwarding when the next beat addresses the same channel. An event is registered
// when its item leaves the parse stage. Reset clears channel activity and pipeline valids;
// memory entries only matter once a start has written them. Input stalls only while the
// parse stage holds a beat and the output register is full and stalled.
`include "assert_macros.svh"

module sound_sequence_event_parser #(
    parameter int CHANNELS = sseq_pkg::CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sseq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sseq_pkg::t_out_item o_out_item
);

    localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                  r_s1_valid;
    sseq_pkg::t_in_item    r_s1_item;
    logic                  r_fwd_hit;
    sseq_pkg::t_chan_state r_fwd_data;
    logic [CHANNELS-1:0]   r_active;
    logic                  r_out_valid;
    sseq_pkg::t_out_item   r_out_item;

    logic                  w_accept;
    logic                  w_fire;
    logic                  w_we;
    logic                  w_in_range;
    logic [CHAN_W+2:0]     w_in_ext;
    logic [CHAN_W+2:0]     w_s1_ext;
    logic [CHAN_W-1:0]     w_in_idx;
    logic [CHAN_W-1:0]     w_s1_idx;
    sseq_pkg::t_chan_state w_rd_data;
    sseq_pkg::t_chan_state w_entry;
    sseq_pkg::t_chan_state w_next;
    sseq_pkg::t_parse_ctl  w_ctl;
    sseq_pkg::t_out_item   w_res;
    logic                  w_emit;

    // Channel indexes at memory width
    assign w_in_ext   = {{CHAN_W{1'b0}}, i_in_item.chan};
    assign w_s1_ext   = {{CHAN_W{1'b0}}, r_s1_item.chan};
    assign w_in_idx   = w_in_ext[CHAN_W-1:0];
    assign w_s1_idx   = w_s1_ext[CHAN_W-1:0];
    assign w_in_range = w_s1_ext < (CHAN_W + 3)'(CHANNELS);

    // Handshake: parse stage advances whenever the output register can take a beat
    assign w_fire     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_we       = w_fire && w_in_range;
    assign w_emit     = w_we && w_ctl.emit;

    sseq_state_mem #(
        .DEPTH  (CHANNELS),
        .ADDR_W (CHAN_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s1_idx),
        .i_wdata (w_next),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_rd_data)
    );

    // Entry for the parse stage, forwarded past a same-edge write
    assign w_entry = r_fwd_hit ? r_fwd_data : w_rd_data;

    sseq_parse u_parse (
        .i_mode   (r_s1_item.mode),
        .i_chan   (r_s1_item.chan),
        .i_byte   (r_s1_item.stream_byte),
        .i_active (r_active[w_s1_idx]),
        .i_entry  (w_entry),
        .o_next   (w_next),
        .o_ctl    (w_ctl),
        .o_res    (w_res)
    );

    // Parse stage register and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= w_we && (w_s1_idx == w_in_idx);
            end else if (w_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item  <= i_in_item;
            r_fwd_data <= w_next;
        end
    end

    // Channel activity flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (w_we) begin
            if (w_ctl.set_active) begin
                r_active[w_s1_idx] <= 1'b1;
            end else if (w_ctl.clr_active) begin
                r_active[w_s1_idx] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `SSEQ_ASSERT(a_fwd_on_same_chan, (w_accept && w_we && (w_s1_idx == w_in_idx)) |=> r_fwd_hit, "same-channel beat not forwarded")
    `SSEQ_ASSERT(a_end_deactivates, (w_emit && w_res.ended) |=> !r_active[$past(w_s1_idx)], "end opcode left channel active")
    `SSEQ_ASSERT(a_out_from_emit, $rose(r_out_valid) |-> $past(w_emit), "output beat without an event")
    `SSEQ_NEVER(a_idle_chan_silent, r_s1_valid && (r_s1_item.mode == sseq_pkg::MODE_STREAM) && !r_active[w_s1_idx] && w_ctl.emit, "event from inactive channel")

endmodule

FILE: bench/sound_sequence_event_parser_tb.sv
// Self-checking bench for sound_sequence_event_parser: directed, hold-off and random tests.
// Predicts each event from its own per-channel parser state; needs sseq_pkg and the block's RTL.
`timescale 1ns / 100ps

module sound_sequence_event_parser_tb;

    localparam int         NCHAN        = sseq_pkg::CHANNELS_DEF;
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [7:0] OPC_NOTE_MAX = 8'h5F;
    localparam logic [7:0] OPC_CTRL_MAX = 8'h7F;
    localparam int         RANDOM_BEATS = 620;
    localparam int         HOLD_CYCLES  = 120;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    sseq_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    sseq_pkg::t_out_item o_out_item;

    // Per-channel parser state as the bench sees it
    logic             chan_on    [NCHAN];
    sseq_pkg::t_phase chan_phase [NCHAN];
    logic [15:0]      chan_accum [NCHAN];
    logic [15:0]      chan_opa   [NCHAN];
    logic [15:0]      chan_opb   [NCHAN];
    logic [6:0]       chan_held  [NCHAN];

    sseq_pkg::t_out_item pending_events[$];

    int  errors         = 0;
    int  events_seen    = 0;
    int  beats_accepted = 0;
    int  items_used     = 0;
    int  idle_cycles    = 0;
    int  burst_left     = 0;
    bit  gaps_on        = 1'b1;
    int  hold_asked     = 0;
    int  hold_done      = 0;

    sound_sequence_event_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Controls that hold back their event for one argument byte
    function automatic logic takes_argument(input logic [7:0] op);
        case (op)
            sseq_pkg::OPC_ARG0, sseq_pkg::OPC_ARG1, sseq_pkg::OPC_ARG3: return 1'b1;
            default: return ((op >= sseq_pkg::OPC_ARG2_LO) && (op <= sseq_pkg::OPC_ARG2_HI)) ||
                            ((op >= sseq_pkg::OPC_ARG4_LO) && (op <= sseq_pkg::OPC_ARG4_HI));
        endcase
    endfunction

    function automatic sseq_pkg::t_out_item make_event(input int c, input logic [6:0] op,
                                                       input logic with_arg,
                                                       input logic [7:0] arg,
                                                       input logic ends);
        sseq_pkg::t_out_item ev;
        ev.event_chan   = c[2:0];
        ev.event_opcode = op;
        ev.is_control   = ({1'b0, op} >= sseq_pkg::OPC_END);
        ev.op_a         = chan_opa[c];
        ev.op_b         = chan_opb[c];
        ev.has_arg      = with_arg;
        ev.ctrl_arg     = arg;
        ev.duration     = chan_opa[c][15] ? 16'd0 - chan_opa[c] : chan_opa[c];
        ev.ended        = ends;
        return ev;
    endfunction

    // Advance the channel state by one accepted beat; queue any event it causes
    task automatic predict_beat(input sseq_pkg::t_in_item it);
        int         c;
        logic [7:0] b;
        bit         fresh;
        c     = it.chan;
        b     = it.stream_byte;
        fresh = 1'b1;
        case (it.mode)
            sseq_pkg::MODE_START: begin
                chan_on[c]    = 1'b1;
                chan_phase[c] = sseq_pkg::PH_IDLE;
                chan_accum[c] = '0;
                chan_opa[c]   = '0;
                chan_opb[c]   = '0;
                chan_held[c]  = '0;
                items_used++;
            end
            sseq_pkg::MODE_STOP: begin
                chan_on[c]    = 1'b0;
                chan_phase[c] = sseq_pkg::PH_IDLE;
                items_used++;
            end
            sseq_pkg::MODE_STREAM: begin
                if (chan_on[c]) begin
                    items_used++;
                    if (chan_phase[c] == sseq_pkg::PH_ARG) begin
                        chan_phase[c] = sseq_pkg::PH_IDLE;
                        pending_events.push_back(make_event(c, chan_held[c], 1'b1, b, 1'b0));
                        fresh = 1'b0;
                    end else if (chan_phase[c] == sseq_pkg::PH_OPA ||
                                 chan_phase[c] == sseq_pkg::PH_OPB) begin
                        if (b[7:6] == 2'b11) begin
                            // continuation: six more bits, top bits fall off
                            chan_accum[c] = {chan_accum[c][9:0], b[5:0]};
                            fresh = 1'b0;
                        end else begin
                            if (chan_phase[c] == sseq_pkg::PH_OPA)
                                chan_opa[c] = 16'd0 - chan_accum[c];
                            else
                                chan_opb[c] = 16'd0 - chan_accum[c];
                            chan_phase[c] = sseq_pkg::PH_IDLE;
                        end
                    end
                    // byte starts something new: operand, end, held control or event
                    if (fresh) begin
                        if (b >= sseq_pkg::BYTE_OPERAND) begin
                            chan_accum[c] = {8'h00, b & sseq_pkg::BYTE_LOW6};
                            chan_phase[c] = (b >= sseq_pkg::BYTE_OP_A) ? sseq_pkg::PH_OPA
                                                                       : sseq_pkg::PH_OPB;
                        end else if (b == sseq_pkg::OPC_END) begin
                            pending_events.push_back(make_event(c, b[6:0], 1'b0, 8'h00, 1'b1));
                            chan_on[c]    = 1'b0;
                            chan_phase[c] = sseq_pkg::PH_IDLE;
                        end else if (takes_argument(b)) begin
                            chan_held[c]  = b[6:0];
                            chan_phase[c] = sseq_pkg::PH_ARG;
                        end else begin
                            pending_events.push_back(make_event(c, b[6:0], 1'b0, 8'h00, 1'b0));
                            chan_phase[c] = sseq_pkg::PH_IDLE;
                        end
                    end
                end
            end
            default: ;  // spare mode, nothing happens
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch on event %0d, expected %h, got %h",
                         $time, name, events_seen, want, got);
        end
    endtask

    task automatic compare_event(input sseq_pkg::t_out_item got);
        sseq_pkg::t_out_item want;
        if (pending_events.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected event, expected none, got %h", $time, got);
            return;
        end
        want = pending_events.pop_front();
        check_field("event_chan",   want.event_chan,   got.event_chan);
        check_field("event_opcode", want.event_opcode, got.event_opcode);
        check_field("is_control",   want.is_control,   got.is_control);
        check_field("op_a",         want.op_a,         got.op_a);
        check_field("op_b",         want.op_b,         got.op_b);
        check_field("has_arg",      want.has_arg,      got.has_arg);
        check_field("ctrl_arg",     want.ctrl_arg,     got.ctrl_arg);
        check_field("duration",     want.duration,     got.duration);
        check_field("ended",        want.ended,        got.ended);
    endtask

    // Output beats are checked before the same edge's input beat is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                events_seen++;
                compare_event(o_out_item);
            end
            if (i_in_valid && !o_in_stall) begin
                beats_accepted++;
                predict_beat(i_in_item);
            end
        end
    end

    // Watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("sound_sequence_event_parser_tb: done, errors");
            $finish;
        end
    end

    // Receiver: stall density changes per segment; long hold-off on request
    initial begin
        int seg_left;
        int density;
        i_out_stall = 1'b0;
        seg_left    = 0;
        density     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asked) begin
                hold_done++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: density = 0;
                        1: density = 20;
                        2: density = 50;
                        default: density = 85;
                    endcase
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                i_out_stall <= ($urandom_range(0, 99) < density);
            end
        end
    end

    // Send one beat in bursts with random gaps; called and returns at a falling edge
    task automatic send_beat(input logic [1:0] mode, input int c, input logic [7:0] b);
        sseq_pkg::t_in_item it;
        it.mode        = mode;
        it.chan        = c[2:0];
        it.stream_byte = b;
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Operand: lead byte then up to five continuation bytes
    task automatic send_operand(input int c, input logic [7:0] lead_base);
        int extra;
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
        send_beat(sseq_pkg::MODE_STREAM, c, lead_base | 8'($urandom_range(0, 63)));
        repeat (extra)
            send_beat(sseq_pkg::MODE_STREAM, c, sseq_pkg::BYTE_OP_A | 8'($urandom_range(0, 63)));
    endtask

    task automatic test_directed;
        // plain notes at both ends of the range
        send_beat(sseq_pkg::MODE_START,  0, 8'h00);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'h00);
        // operand A of 0x8000: negating it gives 0x8000 again, so duration is 0x8000
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hC8);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hC0);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hC0);
        send_beat(sseq_pkg::MODE_STREAM, 0, OPC_NOTE_MAX);
        // long operand B, then a control that takes an argument
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'h81);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hFF);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hFF);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hFF);
        send_beat(sseq_pkg::MODE_STREAM, 0, sseq_pkg::OPC_ARG0);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'hA5);
        // control without argument, then end of channel
        send_beat(sseq_pkg::MODE_STREAM, 0, OPC_CTRL_MAX);
        send_beat(sseq_pkg::MODE_STREAM, 0, sseq_pkg::OPC_END);
        send_beat(sseq_pkg::MODE_STREAM, 0, 8'h10);       // inactive: dropped
        // operand A finished by the lead of operand B
        send_beat(sseq_pkg::MODE_START,  7, 8'hFF);
        send_beat(sseq_pkg::MODE_STREAM, 7, 8'hC1);
        send_beat(sseq_pkg::MODE_STREAM, 7, 8'h85);
        send_beat(sseq_pkg::MODE_STREAM, 7, sseq_pkg::OPC_ARG4_HI);
        send_beat(sseq_pkg::MODE_STREAM, 7, 8'h00);
        // restart while active, stop while waiting for an argument
        send_beat(sseq_pkg::MODE_START,  7, 8'h00);
        send_beat(sseq_pkg::MODE_STREAM, 7, sseq_pkg::OPC_ARG4_LO);
        send_beat(sseq_pkg::MODE_STOP,   7, 8'h00);
        send_beat(sseq_pkg::MODE_STREAM, 7, 8'h05);       // stopped: dropped
        send_beat(MODE_SPARE,            7, 8'hFF);
        send_beat(sseq_pkg::MODE_START,  7, 8'h00);
        send_beat(sseq_pkg::MODE_STREAM, 7, 8'h30);
    endtask

    // Receiver holds off while notes keep coming: the block must fill and stall
    task automatic test_output_hold;
        gaps_on = 1'b0;
        send_beat(sseq_pkg::MODE_START, 3, 8'h00);
        hold_asked++;
        for (int n = 0; n < 40; n++)
            send_beat(sseq_pkg::MODE_STREAM, 3, 8'(n));
        gaps_on = 1'b1;
    endtask

    // Mostly well-formed phrases on random channels, with noise and stray starts/stops
    task automatic test_random_sequences;
        int         first;
        int         c;
        int         r;
        logic [7:0] op;
        first = items_used;
        while (items_used < first + RANDOM_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_beat(2'($urandom_range(0, 3)), $urandom_range(0, NCHAN - 1),
                          8'($urandom_range(0, 255)));
            end else if (r < 14) begin
                send_beat((r < 12) ? sseq_pkg::MODE_STOP : sseq_pkg::MODE_START,
                          $urandom_range(0, NCHAN - 1), 8'($urandom_range(0, 255)));
            end else begin
                c = $urandom_range(0, NCHAN - 1);
                if (!chan_on[c])
                    send_beat(sseq_pkg::MODE_START, c, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 45)
                    send_operand(c, sseq_pkg::BYTE_OP_A);
                if ($urandom_range(0, 99) < 35)
                    send_operand(c, sseq_pkg::BYTE_OPERAND);
                r = $urandom_range(0, 99);
                if (r < 50)
                    op = 8'($urandom_range(0, OPC_NOTE_MAX));
                else if (r < 95)
                    op = 8'($urandom_range(sseq_pkg::OPC_ARG0, OPC_CTRL_MAX));
                else
                    op = sseq_pkg::OPC_END;
                send_beat(sseq_pkg::MODE_STREAM, c, op);
                if (takes_argument(op))
                    send_beat(sseq_pkg::MODE_STREAM, c, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        for (int k = 0; k < NCHAN; k++) begin
            chan_on[k]    = 1'b0;
            chan_phase[k] = sseq_pkg::PH_IDLE;
            chan_accum[k] = '0;
            chan_opa[k]   = '0;
            chan_opb[k]   = '0;
            chan_held[k]  = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed;
        test_output_hold;
        test_random_sequences;

        // drain: wait until all events are in, then keep watching for strays
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats on %0d channels and checked %0d events,",
                 beats_accepted, NCHAN, events_seen);
        $display("with operand chains, argument controls, channel ends, dropped beats, hold-off");
        if (errors == 0)
            $display("sound_sequence_event_parser_tb: done, clean");
        else
            $display("sound_sequence_event_parser_tb: done, errors");
        $finish;
    end

endmodule
